// File: hw/rtl/lnps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnps_pkg: shared types and constants
// Event kinds, note width and the per-cell control bundle of the key stack.
// ----------------------------------------------------------------------------
package lnps_pkg;

    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_NOTE_ON   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VOICE_END = 2'd2;

    // Broadcast to every cell of the chain for one item.
    typedef struct packed {
        logic              note_on;
        logic              note_off;
        logic              clear;
        logic [NOTE_W-1:0] key;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/lnps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnps_cell: one slot of the key stack
// Holds one key and its valid bit, matches the broadcast key, and takes the
// key from the slot above when a removal at or below it closes the gap.
// ----------------------------------------------------------------------------
module lnps_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lnps_pkg::cell_ctrl_t      ctrl,
    input  wire logic                      found,
    input  wire logic [lnps_pkg::NOTE_W-1:0] above_note,
    input  wire logic                      above_valid,
    input  wire logic                      below_valid,
    input  wire logic                      seen_in,
    output logic                           seen_out,
    output logic                           match,
    output logic                           valid,
    output logic [lnps_pkg::NOTE_W-1:0]    stored_note,
    output logic [lnps_pkg::NOTE_W-1:0]    note_next,
    output logic                           valid_next
);

    logic [lnps_pkg::NOTE_W-1:0] note_reg;
    logic                        valid_reg;
    logic                        shift;
    logic                        push;

    assign match       = valid_reg && (note_reg == ctrl.key);
    assign seen_out    = seen_in || match;
    assign valid       = valid_reg;
    assign stored_note = note_reg;

    // Slots at and above the removed key take their upper neighbor.
    assign shift = ctrl.note_off && seen_out;
    // The first empty slot takes a new key.
    assign push  = ctrl.note_on && !found && below_valid && !valid_reg;

    always_comb begin
        note_next  = note_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (shift) begin
            note_next  = above_note;
            valid_next = above_valid;
        end else if (push) begin
            note_next  = ctrl.key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        note_reg <= note_next;
    end

endmodule
`default_nettype wire

// File: hw/rtl/lnps_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lnps_chain: row of stack cells
// Links the cells bottom to top, ripples the match flag upward and picks the
// top key of the updated stack.
// ----------------------------------------------------------------------------
module lnps_chain #(
    parameter int DEPTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lnps_pkg::cell_ctrl_t        ctrl,
    output logic                             found,
    output logic                             full,
    output logic [DEPTH-1:0]                 match_vec,
    output logic [lnps_pkg::NOTE_W-1:0]      top_next
);

    // Stored key of each cell, seen by its lower neighbor during a shift.
    logic [lnps_pkg::NOTE_W-1:0] note_vec  [DEPTH];
    logic [lnps_pkg::NOTE_W-1:0] note_next [DEPTH];
    logic [DEPTH-1:0]            valid_vec;
    logic [DEPTH-1:0]            valid_next;
    logic [DEPTH:0]              seen;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [lnps_pkg::NOTE_W-1:0] up_note;
        logic                        up_valid;
        logic                        down_valid;

        if (i == DEPTH - 1) begin : g_top
            assign up_note  = '0;
            assign up_valid = 1'b0;
        end else begin : g_mid
            assign up_note  = note_vec[i+1];
            assign up_valid = valid_vec[i+1];
        end

        if (i == 0) begin : g_bottom
            assign down_valid = 1'b1;
        end else begin : g_upper
            assign down_valid = valid_vec[i-1];
        end

        lnps_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .found       (found),
            .above_note  (up_note),
            .above_valid (up_valid),
            .below_valid (down_valid),
            .seen_in     (seen[i]),
            .seen_out    (seen[i+1]),
            .match       (match_vec[i]),
            .valid       (valid_vec[i]),
            .stored_note (note_vec[i]),
            .note_next   (note_next[i]),
            .valid_next  (valid_next[i])
        );
    end

    assign found = seen[DEPTH];
    assign full  = valid_vec[DEPTH-1];

    // Top of the updated stack: the highest valid slot.
    always_comb begin
        logic [DEPTH-1:0] above;
        above    = {1'b0, valid_next[DEPTH-1:1]};
        top_next = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (valid_next[i] && !above[i]) begin
                top_next = top_next | note_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/last_note_priority_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// last_note_priority_stack: monophonic last-note-priority key stack
// Keeps held keys in a row of cells; the newest key sounds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one key event per item. s_tuser carries the kind
//   (note on, note off, voice ended); s_tdata carries note, velocity and the
//   voice-silent flag. Output channel m_*: exactly one result item per input
//   item, with the sounding note, gate and retune flags, velocity target and
//   the number of held keys.
//   m_tvalid rises in the cycle after acceptance. An item is taken every
//   cycle while s_tready is high: each cell compares its key with the event
//   in parallel, the match ripples up the row, and every cell loads its
//   shifted or pushed value in the same clock edge.
//   The output register holds a result until it is taken; s_tready stays high
//   while that register is empty or being drained, so a stalled receiver
//   holds off the input after one waiting item.
//   Reset empties the stack, sets the sounding note to 0 and drops any
//   pending result.
// ----------------------------------------------------------------------------
module last_note_priority_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // note[6:0], velocity[13:7], voice_silent[14], pad
    input  wire logic [1:0]  s_tuser,  // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // active_note[6:0], key_held[7], gate_on[8],
                                       // gate_release[9], hard_retune[10],
                                       // glide_retune[11], velocity_out[18:12],
                                       // stack_count[23:19]
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic                        accept;
    logic [lnps_pkg::KIND_W-1:0] kind;
    logic [lnps_pkg::NOTE_W-1:0] key;
    logic [lnps_pkg::VEL_W-1:0]  vel;
    logic                        silent;

    lnps_pkg::cell_ctrl_t        ctrl;
    logic                        found;
    logic                        full;
    logic [STACK_DEPTH-1:0]      match_vec;
    logic [lnps_pkg::NOTE_W-1:0] top_next;

    logic [CW-1:0]               count_reg, count_next;
    logic [lnps_pkg::NOTE_W-1:0] cur_note_reg, cur_note_next;
    logic                        m_valid_reg;
    logic [23:0]                 m_data_reg, m_data_next;

    assign kind   = s_tuser;
    assign key    = s_tdata[6:0];
    assign vel    = s_tdata[13:7];
    assign silent = s_tdata[14];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ctrl          = '0;
        ctrl.key      = key;
        ctrl.note_on  = accept && (kind == lnps_pkg::KIND_NOTE_ON);
        ctrl.note_off = accept && (kind == lnps_pkg::KIND_NOTE_OFF);
        ctrl.clear    = accept && (kind == lnps_pkg::KIND_VOICE_END);
    end

    lnps_chain #(
        .DEPTH (STACK_DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .found     (found),
        .full      (full),
        .match_vec (match_vec),
        .top_next  (top_next)
    );

    always_comb begin
        logic                       key_held;
        logic                       gate_on;
        logic                       gate_rel;
        logic                       hard;
        logic                       glide;
        logic [lnps_pkg::VEL_W-1:0] vel_out;
        logic [CW+4:0]              count_ext;

        key_held      = 1'b0;
        gate_on       = 1'b0;
        gate_rel      = 1'b0;
        hard          = 1'b0;
        glide         = 1'b0;
        vel_out       = '0;
        count_next    = count_reg;
        cur_note_next = cur_note_reg;

        unique case (kind)
            lnps_pkg::KIND_NOTE_ON: begin
                if (!found && !full) begin
                    count_next = count_reg + CW'(1);
                end
                cur_note_next = top_next;
                key_held      = 1'b1;
                gate_on       = 1'b1;
                hard          = silent;
                glide         = !silent;
                vel_out       = vel;
            end
            lnps_pkg::KIND_NOTE_OFF: begin
                if (found) begin
                    count_next = count_reg - CW'(1);
                end
                if (count_next != '0) begin
                    cur_note_next = top_next;
                    key_held      = 1'b1;
                    glide         = 1'b1;
                end else begin
                    gate_rel = 1'b1;
                end
            end
            lnps_pkg::KIND_VOICE_END: begin
                count_next = '0;
            end
            default: begin
                key_held = (count_reg != '0);
            end
        endcase

        count_ext   = {5'b0, count_next};
        m_data_next = {count_ext[4:0], vel_out, glide, hard, gate_rel, gate_on,
                       key_held, cur_note_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            cur_note_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                cur_note_reg <= cur_note_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Keys in the stack are unique, so at most one cell can match.
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("more than one stack cell matches the key");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("held key count exceeds stack depth");

    a_note_on_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.note_on |=> (m_tvalid && m_tdata[8] && m_tdata[7]))
        else $error("note on did not open the gate");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> (count_reg == '0 && m_tdata[23:19] == 5'd0))
        else $error("voice end left keys in the stack");

endmodule
`default_nettype wire
